// ----- sv/pfbm_pkg.sv -----
package pfbm_pkg;

  // Page geometry: 4 KiB pages, 64 pages to one bitmap word.
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_SHIFT = 6;

  // Page numbers derived from a byte address sum of 54 bits.
  localparam int PG_W = 42;

  // Commands.
  localparam logic [1:0] CMD_REGION    = 2'd0;
  localparam logic [1:0] CMD_PAGE_USED = 2'd1;
  localparam logic [1:0] CMD_PAGE_FREE = 2'd2;

  // Region types; every other code is treated as unknown.
  localparam logic [3:0] RT_USABLE         = 4'd0;
  localparam logic [3:0] RT_RESERVED       = 4'd1;
  localparam logic [3:0] RT_ACPI_RECLAIM   = 4'd2;
  localparam logic [3:0] RT_ACPI_NVS       = 4'd3;
  localparam logic [3:0] RT_BAD            = 4'd4;
  localparam logic [3:0] RT_LOADER_RECLAIM = 4'd5;
  localparam logic [3:0] RT_KERNEL         = 4'd6;
  localparam logic [3:0] RT_FRAMEBUFFER    = 4'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [51:0] region_base;
    logic [51:0] region_length;
    logic [3:0]  region_type;
    logic [17:0] page_index;
  } in_word_t;

  typedef struct packed {
    logic [63:0] total_overall;
    logic [63:0] total_usable;
    logic [63:0] total_unusable;
    logic [63:0] total_bad;
    logic [31:0] entries_counted;
    logic        out_of_range;
  } out_word_t;

endpackage

// ----- sv/page_frame_bitmap_marker_top.sv -----
// Each accepted word passes the sum, range and setup steps; when the region or page
// covers bitmap words they are then walked (one word read per cycle, the modify-write
// following in the cycle after the read) and flushed before the result is loaded.
// A new word is taken only once the last is done; in_ready returns the cycle after the
// result is loaded, which waits while an earlier result is held back by out_ready.
// Reset clears the totals, then sweeps every bitmap word to zero.
module page_frame_bitmap_marker_top
  import pfbm_pkg::*;
#(
  parameter int BITMAP_WORDS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // Word address width, page index width within the bitmap, and a width that
  // can also hold the page limit itself.
  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int PW = AW + WORD_SHIFT;
  localparam int LW = PW + 1;
  localparam logic [PG_W-1:0] LIMIT_PG = PG_W'(BITMAP_WORDS) << WORD_SHIFT;
  localparam logic [LW-1:0]   LIMIT_LW = LW'(BITMAP_WORDS) << WORD_SHIFT;
  localparam logic [AW-1:0]   LAST_WORD = AW'(BITMAP_WORDS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_RANGE = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]      state;
  logic [AW-1:0]   clr;
  in_word_t        item;

  logic [63:0]     overall_sum;
  logic [63:0]     usable_sum;
  logic [63:0]     unusable_sum;
  logic [63:0]     bad_sum;
  logic [31:0]     entries_seen;

  logic            mark;
  logic            op_set;
  logic            oor;
  logic            walk_go;
  logic [PG_W-1:0] first_pg;
  logic [PG_W-1:0] end_pg;
  logic [LW-1:0]   end_lim;
  logic [AW-1:0]   w;
  logic [AW-1:0]   wfirst;
  logic [AW-1:0]   wlast;
  logic [5:0]      lo;
  logic [5:0]      hi;

  // Read-modify-write pipeline into the bitmap.
  logic            p_valid;
  logic            p_set;
  logic [AW-1:0]   p_addr;
  logic [63:0]     p_mask;
  logic [63:0]     rd_data;
  logic [63:0]     page_bits [BITMAP_WORDS];

  logic [53:0]     byte_end;
  logic [PW-1:0]   endm1;
  logic            nonempty;
  logic            over;
  logic [5:0]      lo_eff;
  logic [5:0]      hi_eff;
  logic [63:0]     walk_mask;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [63:0]     wr_data;

  assign in_ready = (state == S_IDLE);

  // Region end rounded up to a page boundary.
  assign byte_end = {2'b00, item.region_base} + {2'b00, item.region_length} + 54'd4095;

  // Range checks against the end of the bitmap.
  assign nonempty = end_pg > first_pg;
  assign over     = end_pg > LIMIT_PG;
  assign endm1    = PW'(end_lim - LW'(1));

  // Bit span of the current word; the edge words are partial.
  assign lo_eff    = (w == wfirst) ? lo : 6'd0;
  assign hi_eff    = (w == wlast) ? hi : 6'd63;
  assign walk_mask = ({64{1'b1}} << lo_eff) & ({64{1'b1}} >> (6'd63 - hi_eff));

  // The clearing sweep and the pipeline share the single write port.
  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr;
      wr_data = '0;
    end else begin
      wr_en   = p_valid;
      wr_addr = p_addr;
      wr_data = p_set ? (rd_data | p_mask) : (rd_data & ~p_mask);
    end
  end

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_bits[wr_addr] <= wr_data;
    end
    rd_data <= page_bits[w];
  end

  // Write stage follows the read in the next cycle.
  always_ff @(posedge clk) begin
    p_addr <= w;
    p_mask <= walk_mask;
    p_set  <= op_set;
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == S_WALK);
    end
  end

  // Sequencer and running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      overall_sum  <= '0;
      usable_sum   <= '0;
      unusable_sum <= '0;
      bad_sum      <= '0;
      entries_seen <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          op_set <= (item.cmd != CMD_PAGE_FREE);
          if (item.cmd == CMD_REGION) begin
            first_pg     <= PG_W'(item.region_base >> PAGE_SHIFT);
            end_pg       <= byte_end[53:PAGE_SHIFT];
            overall_sum  <= overall_sum + 64'(item.region_length);
            entries_seen <= entries_seen + 32'd1;
            unique case (item.region_type)
              RT_USABLE, RT_ACPI_RECLAIM, RT_LOADER_RECLAIM: begin
                usable_sum <= usable_sum + 64'(item.region_length);
                mark       <= 1'b0;
              end
              RT_RESERVED, RT_ACPI_NVS, RT_KERNEL, RT_FRAMEBUFFER: begin
                unusable_sum <= unusable_sum + 64'(item.region_length);
                mark         <= 1'b1;
              end
              default: begin
                bad_sum <= bad_sum + 64'(item.region_length);
                mark    <= 1'b1;
              end
            endcase
          end else begin
            // A single page is the one-page range [page, page + 1).
            first_pg <= PG_W'(item.page_index);
            end_pg   <= PG_W'(item.page_index) + PG_W'(1);
            mark     <= (item.cmd == CMD_PAGE_USED) || (item.cmd == CMD_PAGE_FREE);
          end
          state <= S_RANGE;
        end
        S_RANGE: begin
          oor     <= mark && nonempty && over;
          walk_go <= mark && (over ? (first_pg < LIMIT_PG) : nonempty);
          end_lim <= over ? LIMIT_LW : end_pg[LW-1:0];
          state   <= S_SETUP;
        end
        S_SETUP: begin
          w      <= first_pg[PW-1:WORD_SHIFT];
          wfirst <= first_pg[PW-1:WORD_SHIFT];
          wlast  <= endm1[PW-1:WORD_SHIFT];
          lo     <= first_pg[5:0];
          hi     <= endm1[5:0];
          state  <= walk_go ? S_WALK : S_OUT;
        end
        S_WALK: begin
          if (w == wlast) begin
            state <= S_FLUSH;
          end else begin
            w <= w + AW'(1);
          end
        end
        S_FLUSH: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Output register; the next word may be accepted while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid                <= 1'b1;
      out_data.total_overall   <= overall_sum;
      out_data.total_usable    <= usable_sum;
      out_data.total_unusable  <= unusable_sum;
      out_data.total_bad       <= bad_sum;
      out_data.entries_counted <= entries_seen;
      out_data.out_of_range    <= oor;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The write pipeline has drained before a new word is taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !p_valid)
    else $error("bitmap write pending while accepting a word");

  // Writes come only from words read during the walk.
  a_write_from_walk: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(state) == S_WALK)
    else $error("bitmap write without a walk read");

  // The walk never passes its last word.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (w <= wlast && wlast <= LAST_WORD))
    else $error("walk beyond its last bitmap word");

  // A result appears only at the end of an item.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output step");

  // A clipped range never reaches past the bitmap.
  a_clip: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP && walk_go) |-> (end_lim <= LIMIT_LW && end_lim != '0))
    else $error("clipped range end out of bounds");

endmodule

// ----- dv/page_frame_bitmap_marker_top_tb.sv -----
`timescale 1ns / 100ps

module page_frame_bitmap_marker_top_tb;
  import pfbm_pkg::*;

  localparam int BITMAP_WORDS = 4096;
  localparam int HANG_LIMIT = 30000;
  localparam int RANDOM_WORDS = 1300;
  localparam int MAX_REPORTS = 40;

  // The one command code the package leaves unnamed; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [63:0] PAGE_LIMIT = 64'(BITMAP_WORDS) << WORD_SHIFT;
  localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [51:0] MAP_BYTES = 52'(BITMAP_WORDS) << (WORD_SHIFT + PAGE_SHIFT);
  localparam logic [51:0] ADDR_MAX = '1;
  localparam logic [17:0] PAGE_MAX = '1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Shadow of the block's state, kept by the predictor.
  logic [63:0] page_map [BITMAP_WORDS] = '{default: '0};
  logic [63:0] sum_overall = '0;
  logic [63:0] sum_usable = '0;
  logic [63:0] sum_unusable = '0;
  logic [63:0] sum_bad = '0;
  logic [31:0] region_count = '0;

  out_word_t pending_totals [$];
  int        error_count = 0;
  bit        sender_steady = 1'b0;
  bit        sink_steady = 1'b0;
  int        sink_hold = 0;
  int        sink_roll;
  int        quiet_cycles = 0;

  page_frame_bitmap_marker_top #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Applies one word to the shadow state and returns the totals it reports.
  task automatic account_word(input in_word_t w, output out_word_t r);
    logic [63:0] len64;
    logic [63:0] first_pg;
    logic [63:0] stop_pg;
    logic [63:0] last_pg;
    logic [63:0] mask;
    longint unsigned wi;
    int lo;
    int hi;
    bit marks;
    bit skipped;
    marks = 1'b1;
    skipped = 1'b0;
    len64 = 64'(w.region_length);
    unique case (w.cmd)
      CMD_REGION: begin
        sum_overall += len64;
        unique case (w.region_type)
          RT_USABLE, RT_ACPI_RECLAIM, RT_LOADER_RECLAIM: begin
            sum_usable += len64;
            marks = 1'b0;
          end
          RT_RESERVED, RT_ACPI_NVS, RT_KERNEL, RT_FRAMEBUFFER: begin
            sum_unusable += len64;
          end
          default: begin
            sum_bad += len64;
          end
        endcase
        region_count += 32'd1;
        // Every page that holds a byte of the region is marked; pages past the
        // end of the bitmap are dropped and flagged.
        if (marks) begin
          first_pg = 64'(w.region_base) >> PAGE_SHIFT;
          stop_pg = (64'(w.region_base) + len64 + PAGE_MASK) >> PAGE_SHIFT;
          if (stop_pg > first_pg) begin
            if (stop_pg > PAGE_LIMIT) begin
              skipped = 1'b1;
              stop_pg = PAGE_LIMIT;
            end
            if (first_pg < stop_pg) begin
              last_pg = stop_pg - 64'd1;
              for (wi = first_pg >> WORD_SHIFT; wi <= (last_pg >> WORD_SHIFT); wi++) begin
                lo = (wi == (first_pg >> WORD_SHIFT)) ? int'(first_pg[5:0]) : 0;
                hi = (wi == (last_pg >> WORD_SHIFT)) ? int'(last_pg[5:0]) : 63;
                mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (63 - hi));
                page_map[wi] |= mask;
              end
            end
          end
        end
      end
      CMD_PAGE_USED, CMD_PAGE_FREE: begin
        wi = 64'(w.page_index) >> WORD_SHIFT;
        if (wi >= BITMAP_WORDS) begin
          skipped = 1'b1;
        end else if (w.cmd == CMD_PAGE_USED) begin
          page_map[wi][w.page_index[5:0]] = 1'b1;
        end else begin
          page_map[wi][w.page_index[5:0]] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.total_overall = sum_overall;
    r.total_usable = sum_usable;
    r.total_unusable = sum_unusable;
    r.total_bad = sum_bad;
    r.entries_counted = region_count;
    r.out_of_range = skipped;
  endtask

  function automatic in_word_t make_word(logic [1:0] op, logic [51:0] base,
                                         logic [51:0] len, logic [3:0] kind,
                                         logic [17:0] page);
    in_word_t w;
    w.cmd = op;
    w.region_base = base;
    w.region_length = len;
    w.region_type = kind;
    w.page_index = page;
    return w;
  endfunction

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_steady || roll < 55) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Random word. Marking regions are mostly small so the bitmap walk stays short;
  // a few lie anywhere in the address space or run from inside the bitmap past its end.
  function automatic in_word_t random_word();
    in_word_t w;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) w.cmd = CMD_REGION;
    else if (roll < 75) w.cmd = CMD_PAGE_USED;
    else if (roll < 95) w.cmd = CMD_PAGE_FREE;
    else w.cmd = CMD_UNUSED;
    w.region_base = 52'({$urandom, $urandom});
    w.region_length = 52'({$urandom, $urandom});
    w.region_type = 4'($urandom);
    w.page_index = 18'($urandom);
    if (w.cmd == CMD_REGION &&
        !(w.region_type inside {RT_USABLE, RT_ACPI_RECLAIM, RT_LOADER_RECLAIM})) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        w.region_base = 52'($urandom) & (MAP_BYTES - 52'd1);
        w.region_length = 52'($urandom_range(0, 1 << 18));
      end else if (roll < 85) begin
        w.region_base = 52'($urandom) & (MAP_BYTES - 52'd1);
        w.region_length = 52'($urandom_range(0, 1 << 24));
      end else if (roll < 93) begin
        // Straddles the top of the bitmap.
        w.region_base = MAP_BYTES - 52'($urandom_range(1, 1 << 16));
        w.region_length = 52'($urandom_range(0, 1 << 17));
      end else if (roll >= 98) begin
        w.region_base = 52'($urandom) & (MAP_BYTES - 52'd1);
      end
    end
    return w;
  endfunction

  // Presents one word and holds it until the block takes it.
  task automatic send_word(input in_word_t w);
    int gap;
    out_word_t want;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    account_word(w, want);
    pending_totals.push_back(want);
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    end
  endtask

  task automatic test_page_commands();
    send_word(make_word(CMD_PAGE_USED, '0, '0, RT_USABLE, PAGE_MAX));
    send_word(make_word(CMD_PAGE_FREE, ADDR_MAX, ADDR_MAX, '1, '0));
    send_word(make_word(CMD_UNUSED, ADDR_MAX, ADDR_MAX, '1, PAGE_MAX));
  endtask

  task automatic test_region_types();
    for (int t = 0; t < 16; t++) begin
      send_word(make_word(CMD_REGION, 52'(t * 'h5000 + 'h123), 52'('h3000 + t),
                          4'(t), 18'(t)));
    end
  endtask

  task automatic test_region_edges();
    // Zero length at an unaligned base still touches the page it sits in.
    send_word(make_word(CMD_REGION, 52'h1234, '0, RT_RESERVED, '0));
    send_word(make_word(CMD_REGION, 52'h8000, '0, RT_BAD, '0));
    // Entirely beyond the bitmap.
    send_word(make_word(CMD_REGION, ADDR_MAX, ADDR_MAX, RT_BAD, '0));
    // Covers every word of the bitmap and runs past it.
    send_word(make_word(CMD_REGION, '0, ADDR_MAX, RT_KERNEL, '0));
    send_word(make_word(CMD_REGION, MAP_BYTES - 52'd4096, 52'd8192, RT_FRAMEBUFFER, '0));
    // Ends exactly at the top of the bitmap, so nothing is skipped.
    send_word(make_word(CMD_REGION, MAP_BYTES - 52'd8192, 52'd8192, RT_ACPI_NVS, '0));
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 20; i++) send_word(random_word());
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_word(random_word());
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < RANDOM_WORDS / 100; chunk++) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100; i++) send_word(random_word());
    end
    sender_steady = 1'b0;
  endtask

  // Output side: random stalls, mostly short, with calm spells that never stall.
  always @(posedge clk) begin
    sink_roll = $urandom_range(0, 99);
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (!sink_steady && sink_roll < 25) begin
      out_ready <= 1'b0;
      sink_hold <= (sink_roll < 3) ? $urandom_range(8, 60) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 399) == 0) sink_steady <= !sink_steady;
  end

  // Each result word is compared with the oldest predicted totals.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_totals.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        out_word_t want;
        want = pending_totals.pop_front();
        check_field("total_overall", want.total_overall, out_data.total_overall);
        check_field("total_usable", want.total_usable, out_data.total_usable);
        check_field("total_unusable", want.total_unusable, out_data.total_unusable);
        check_field("total_bad", want.total_bad, out_data.total_bad);
        check_field("entries_counted", 64'(want.entries_counted),
                    64'(out_data.entries_counted));
        check_field("out_of_range", 64'(want.out_of_range), 64'(out_data.out_of_range));
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: timeout, no word moved for %0d cycles", $time, HANG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_page_commands();
    test_region_types();
    test_region_edges();
    test_pause_until_drained();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- page_frame_bitmap_marker_top.f -----
sv/pfbm_pkg.sv
sv/page_frame_bitmap_marker_top.sv
dv/page_frame_bitmap_marker_top_tb.sv
